### hw/rtl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types and constants of the median filter window core.
// ----------------------------------------------------------------------------
package mfw_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int MAX_WINDOW_DEF = 15;

    localparam int PIX_W   = 8;
    localparam int LANES   = 3;
    localparam int WORD_W  = PIX_W * LANES;
    localparam int CNT_W   = 8;   // up to 15*15 window pixels
    localparam int COORD_W = 8;

    // command codes (s_tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // status codes (m_tuser)
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_OOB  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] rank;
        logic             vld;
        logic             last;
        logic [2:0]       bit_idx;
    } sel_ctl_t;

endpackage

### hw/rtl/median_filter_window_core.sv
// ----------------------------------------------------------------------------
// median_filter_window_core
// Frame store of Y/Cb/Cr pixels with a per-channel window median query.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                      | Contents
// s_      | in  | tvalid tready tdata tuser    | command, position, pixel
// m_      | out | tvalid tready tdata tuser    | three medians, status
// cfg_    | in  | valid ready index data       | width, height, window size
//
// A query runs a setup step and then eight bit passes over the N window
// pixels inside the image (N up to 225), each pass sweeping the window
// through the single read port of the frame memory and ending in a drain step.
// Reset restores the registers; the frame memory is not cleared.
// A waiting result holds the block; a new item is taken when the output slot
// is free or being emptied.
// ----------------------------------------------------------------------------
module median_filter_window_core #(
    parameter int MAX_WIDTH  = mfw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mfw_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW = mfw_pkg::MAX_WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[6:0] col[13:7] luma[21:14] blue[29:22] red[37:30]
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // luma[7:0] blue[15:8] red[23:16]
    output logic [0:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = mfw_pkg::COORD_W;

    mfw_pkg::state_t state_reg, state_next;

    logic [7:0] width_reg, height_reg;
    logic [3:0] window_reg;

    logic [CW-1:0] r0_reg, r1_reg, c0_reg, c1_reg, r_reg, c_reg;
    logic [2:0]    bit_reg;
    logic          rd_vld_reg, rd_last_reg;

    logic                      m_valid_reg;
    logic [mfw_pkg::WORD_W-1:0] m_data_reg;
    logic                      m_status_reg;

    // input fields
    logic [6:0] in_row, in_col;
    logic       in_cmd;
    logic [mfw_pkg::WORD_W-1:0] in_word;
    assign in_row  = s_tdata[6:0];
    assign in_col  = s_tdata[13:7];
    assign in_word = {s_tdata[37:30], s_tdata[29:22], s_tdata[21:14]};
    assign in_cmd  = s_tuser[0];

    // effective geometry
    logic [8:0] eff_w, eff_h;
    logic [3:0] eff_s, half, hoff;
    assign eff_w = (32'(width_reg) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, width_reg};
    assign eff_h = (32'(height_reg) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, height_reg};
    always_comb begin
        if (window_reg == '0) begin
            eff_s = 4'd1;
        end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
            eff_s = 4'(MAX_WINDOW);
        end else begin
            eff_s = window_reg;
        end
    end
    assign half = eff_s >> 1;
    assign hoff = eff_s - 4'd1 - half;

    logic oob;
    assign oob = ({2'b0, in_row} >= eff_h) || ({2'b0, in_col} >= eff_w);

    // clipped window bounds
    logic [8:0] rhi, chi;
    logic [CW-1:0] r0_c, r1_c, c0_c, c1_c;
    assign r0_c = ({1'b0, in_row} >= {4'b0, half}) ? CW'({1'b0, in_row} - {4'b0, half}) : '0;
    assign c0_c = ({1'b0, in_col} >= {4'b0, half}) ? CW'({1'b0, in_col} - {4'b0, half}) : '0;
    assign rhi  = {2'b0, in_row} + {5'b0, hoff};
    assign chi  = {2'b0, in_col} + {5'b0, hoff};
    assign r1_c = (rhi < eff_h) ? CW'(rhi) : CW'(eff_h - 9'd1);
    assign c1_c = (chi < eff_w) ? CW'(chi) : CW'(eff_w - 9'd1);

    logic s_acc, out_free, at_last;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign at_last  = (r_reg == r1_reg) && (c_reg == c1_reg);

    // rank = count/2
    logic [3:0] n_rows, n_cols;
    logic [mfw_pkg::CNT_W-1:0] win_cnt;
    assign n_rows  = 4'(r1_reg - r0_reg) + 4'd1;
    assign n_cols  = 4'(c1_reg - c0_reg) + 4'd1;
    assign win_cnt = {4'b0, n_rows} * {4'b0, n_cols};

    // memory addressing
    logic [31:0] wr_lin, rd_lin;
    assign wr_lin = 32'(in_row) * 32'(MAX_WIDTH) + 32'(in_col);
    assign rd_lin = 32'(r_reg) * 32'(MAX_WIDTH) + 32'(c_reg);

    logic mem_we, mem_re;
    logic [mfw_pkg::WORD_W-1:0] mem_rdata, med;
    mfw_pkg::sel_ctl_t sel_ctl;

    mfw_ram #(
        .WIDTH (mfw_pkg::WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_frame (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(wr_lin[ADDR_W-1:0]),
        .wdata(in_word),
        .re   (mem_re),
        .raddr(rd_lin[ADDR_W-1:0]),
        .rdata(mem_rdata)
    );

    mfw_select u_select (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (sel_ctl),
        .pix    (mem_rdata),
        .med    (med)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfw_pkg::ST_IDLE: begin
                if (s_acc && !oob && (in_cmd == mfw_pkg::CMD_QUERY)) begin
                    state_next = mfw_pkg::ST_SETUP;
                end
            end
            mfw_pkg::ST_SETUP: state_next = mfw_pkg::ST_SWEEP;
            mfw_pkg::ST_SWEEP: begin
                if (at_last) begin
                    state_next = mfw_pkg::ST_DRAIN;
                end
            end
            mfw_pkg::ST_DRAIN: begin
                state_next = (bit_reg == '0) ? mfw_pkg::ST_FINISH : mfw_pkg::ST_SWEEP;
            end
            mfw_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mfw_pkg::ST_IDLE;
                end
            end
            default: state_next = mfw_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready        = 1'b0;
        mem_re          = 1'b0;
        sel_ctl.start   = 1'b0;
        sel_ctl.rank    = win_cnt >> 1;
        sel_ctl.vld     = rd_vld_reg;
        sel_ctl.last    = rd_last_reg;
        sel_ctl.bit_idx = bit_reg;
        case (state_reg)
            mfw_pkg::ST_IDLE:  s_tready      = out_free;
            mfw_pkg::ST_SETUP: sel_ctl.start = 1'b1;
            mfw_pkg::ST_SWEEP: mem_re        = 1'b1;
            default: ;
        endcase
    end
    assign mem_we = s_acc && !oob && (in_cmd == mfw_pkg::CMD_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mfw_pkg::ST_IDLE;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            width_reg   <= 8'd128;
            height_reg  <= 8'd128;
            window_reg  <= 4'd9;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= mem_re;
            rd_last_reg <= mem_re && at_last;
            if (cfg_valid) begin
                case (cfg_index)
                    mfw_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    mfw_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    mfw_pkg::REG_WINDOW: window_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if ((s_acc && (oob || (in_cmd == mfw_pkg::CMD_WRITE))) ||
                (state_reg == mfw_pkg::ST_FINISH && out_free)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window walk and result payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            r0_reg       <= r0_c;
            r1_reg       <= r1_c;
            c0_reg       <= c0_c;
            c1_reg       <= c1_c;
            m_data_reg   <= '0;
            m_status_reg <= oob ? mfw_pkg::STAT_OOB : mfw_pkg::STAT_DONE;
        end
        case (state_reg)
            mfw_pkg::ST_SETUP: begin
                r_reg   <= r0_reg;
                c_reg   <= c0_reg;
                bit_reg <= 3'd7;
            end
            mfw_pkg::ST_SWEEP: begin
                if (c_reg == c1_reg) begin
                    c_reg <= c0_reg;
                    r_reg <= r_reg + CW'(1);
                end else begin
                    c_reg <= c_reg + CW'(1);
                end
            end
            mfw_pkg::ST_DRAIN: begin
                r_reg   <= r0_reg;
                c_reg   <= c0_reg;
                bit_reg <= bit_reg - 3'd1;
            end
            mfw_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_data_reg   <= med;
                    m_status_reg <= mfw_pkg::STAT_DONE;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;
    assign cfg_ready  = 1'b1;

    // checks
    a_sweep_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfw_pkg::ST_SWEEP) |-> (r_reg <= r1_reg))
        else $error("window walk past last row");

    a_drain_has_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfw_pkg::ST_DRAIN) |-> (rd_vld_reg && rd_last_reg))
        else $error("pass ended without last read data");

    a_accept_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> (!m_valid_reg || m_tready))
        else $error("item taken while result slot blocked");

    a_no_write_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == mfw_pkg::ST_IDLE))
        else $error("frame write during a query");

endmodule

### hw/rtl/mfw_ram.sv
// ----------------------------------------------------------------------------
// mfw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfw_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/mfw_select.sv
// ----------------------------------------------------------------------------
// mfw_select
// Bitwise radix selection of the k-th smallest value, one lane per channel.
// Each pass counts matching pixels with the current bit clear, MSB first.
// ----------------------------------------------------------------------------
module mfw_select (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mfw_pkg::sel_ctl_t            ctl,
    input  logic [mfw_pkg::WORD_W-1:0]   pix,
    output logic [mfw_pkg::WORD_W-1:0]   med
);

    genvar j;
    generate
        for (j = 0; j < mfw_pkg::LANES; j++) begin : g_lane
            logic [mfw_pkg::PIX_W-1:0] prefix_reg;
            logic [mfw_pkg::CNT_W-1:0] rank_reg;
            logic [mfw_pkg::CNT_W-1:0] cnt_reg;
            logic [mfw_pkg::PIX_W-1:0] val;
            logic [mfw_pkg::PIX_W-1:0] hi_mask;
            logic                      hit;
            logic [mfw_pkg::CNT_W-1:0] cnt_next;

            assign val      = pix[j*mfw_pkg::PIX_W +: mfw_pkg::PIX_W];
            // bits above the one under test must equal the prefix found so far
            assign hi_mask  = 8'hFE << ctl.bit_idx;
            assign hit      = (((val ^ prefix_reg) & hi_mask) == '0) && !val[ctl.bit_idx];
            assign cnt_next = cnt_reg + mfw_pkg::CNT_W'(hit);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cnt_reg <= '0;
                end else if (ctl.start) begin
                    cnt_reg <= '0;
                end else if (ctl.vld) begin
                    cnt_reg <= ctl.last ? '0 : cnt_next;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl.start) begin
                    prefix_reg <= '0;
                    rank_reg   <= ctl.rank;
                end else if (ctl.vld && ctl.last && (rank_reg >= cnt_next)) begin
                    prefix_reg[ctl.bit_idx] <= 1'b1;
                    rank_reg                <= rank_reg - cnt_next;
                end
            end

            assign med[j*mfw_pkg::PIX_W +: mfw_pkg::PIX_W] = prefix_reg;
        end
    endgenerate

endmodule
